### hdl/ppis_pkg.sv
// Shared constants, word types and helper functions for the packed palette index store.
// Used by every module of the block; depends on nothing.
package ppis_pkg;

    localparam int STORE_WORDS    = 4096;
    localparam int MAX_ENTRY_BITS = 12;
    localparam int WORD_BITS      = 64;
    localparam int OFF_W          = $clog2(WORD_BITS);
    localparam int STORE_BITS     = STORE_WORDS * WORD_BITS;
    localparam int FILL_W         = $clog2(STORE_BITS + 1);
    localparam int WIDX_W         = FILL_W - OFF_W;

    localparam int CMD_W = 2;
    localparam int VAL_W = 12;
    localparam int IDX_W = 17;
    localparam int PAL_W = 13;
    localparam int CNT_W = 18;
    localparam int ST_W  = 2;

    localparam int EW_W    = $clog2(MAX_ENTRY_BITS + 1);
    localparam int START_W = IDX_W + EW_W;
    localparam int K_W     = START_W - OFF_W;
    localparam int KC_W    = (K_W > WIDX_W) ? K_W : WIDX_W;
    localparam int EXT_W   = WORD_BITS + MAX_ENTRY_BITS;

    localparam int BANK_DEPTH = STORE_WORDS / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [CNT_W-1:0] ENTRY_LIMIT = CNT_W'(STORE_BITS / 2);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AIR_INDEX     = 1'd1;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_INDEX = 2'd1;
    localparam logic [ST_W-1:0] ST_VALUE = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] index;
    } item_t;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] entry_count;
    } result_t;

    // decoded command handed from front to back
    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic                      val_bad;
        logic [EW_W-1:0]           width;
        logic [MAX_ENTRY_BITS-1:0] entry;
        logic [IDX_W-1:0]          index;
        logic [START_W-1:0]        start;
    } op_t;

    // entry width: bit length of palette_count-1, clamped to [2, MAX_ENTRY_BITS]
    function automatic logic [EW_W-1:0] entry_bits(input logic [PAL_W-1:0] pc);
        logic [PAL_W-1:0]               top;
        logic [$clog2(PAL_W+1)-1:0]     n;
        top = (pc == '0) ? '0 : pc - 1'b1;
        n   = '0;
        for (int i = 0; i < PAL_W; i++)
        begin
            if (top[i])
            begin
                n = ($clog2(PAL_W+1))'(i + 1);
            end
        end
        if (n < 2)
        begin
            n = ($clog2(PAL_W+1))'(2);
        end
        if (n > MAX_ENTRY_BITS)
        begin
            n = ($clog2(PAL_W+1))'(MAX_ENTRY_BITS);
        end
        return EW_W'(n);
    endfunction

    function automatic logic [MAX_ENTRY_BITS-1:0] entry_mask(input logic [EW_W-1:0] w);
        logic [MAX_ENTRY_BITS-1:0] m;
        for (int i = 0; i < MAX_ENTRY_BITS; i++)
        begin
            m[i] = (i < w);
        end
        return m;
    endfunction

endpackage

### hdl/ppis_front.sv
// Front end: configuration registers, item intake and decode (air swap, range check,
// entry width, bit start of a read). Depends on ppis_pkg.
module ppis_front
    import ppis_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item,
    input  logic                  q_full,
    output logic                  push,
    output op_t                   push_op
);

    logic [PAL_W-1:0] palette_count_reg;
    logic [VAL_W-1:0] air_index_reg;
    logic [EW_W-1:0]  width;
    logic [VAL_W-1:0] swapped;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_count_reg <= PAL_W'(1);
            air_index_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PALETTE_COUNT: palette_count_reg <= cfg_data[PAL_W-1:0];
                REG_AIR_INDEX:     air_index_reg     <= cfg_data[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        width = entry_bits(palette_count_reg);
        if (item.value == '0)
        begin
            swapped = air_index_reg;
        end
        else if (item.value == air_index_reg)
        begin
            swapped = '0;
        end
        else
        begin
            swapped = item.value;
        end
        push_op.command = item.command;
        push_op.val_bad = (PAL_W'(item.value) >= palette_count_reg)
                       || (PAL_W'(swapped) >= palette_count_reg);
        push_op.width   = width;
        push_op.entry   = MAX_ENTRY_BITS'(swapped) & entry_mask(width);
        push_op.index   = item.index;
        push_op.start   = START_W'(item.index) * START_W'(width);
    end

    assign item_stall = q_full;
    assign push       = item_valid && !q_full;

endmodule

### hdl/ppis_queue.sv
// Short FIFO of decoded commands between front and back.
// Depends on ppis_pkg.
module ppis_queue
    import ppis_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output op_t  head
);

    op_t               q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_op;
        end
    end

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = q_mem[rd_ptr_reg];

endmodule

### hdl/ppis_back.sv
// Back end: fill state, partial word accumulator, even/odd word banks, read extraction
// and the result register. Depends on ppis_pkg.
module ppis_back
    import ppis_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    head_valid,
    input  op_t     head,
    output logic    pop,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    localparam logic [1:0] SRC_ZERO = 2'd0;
    localparam logic [1:0] SRC_MEM  = 2'd1;
    localparam logic [1:0] SRC_PART = 2'd2;

    typedef struct packed {
        logic                k_odd;
        logic [OFF_W-1:0]    off;
        logic [EW_W-1:0]     width;
        logic [1:0]          src_lo;
        logic [1:0]          src_hi;
    } rd_ctl_t;

    logic [WORD_BITS-1:0] even_mem [BANK_DEPTH];
    logic [WORD_BITS-1:0] odd_mem  [BANK_DEPTH];

    logic                 state_reg, state_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [WORD_BITS-1:0] partial_reg, partial_next;
    logic                 res_valid_reg, res_valid_next;
    result_t              res_reg, res_next;
    rd_ctl_t              rd_ctl_reg, rd_ctl_next;
    logic [WORD_BITS-1:0] rd_even_reg, rd_odd_reg;

    logic                 free, start_op, load;
    logic [OFF_W-1:0]     pos;
    logic [WIDX_W-1:0]    cur;
    logic [EXT_W-1:0]     ext;
    logic [WORD_BITS-1:0] merged;
    logic [FILL_W:0]      fill_sum;
    logic [OFF_W:0]       pos_sum;
    logic                 no_room, word_done;
    logic [K_W-1:0]       k, k1;
    logic [BANK_AW-1:0]   even_addr, odd_addr, wr_addr;
    logic                 wr_en, rd_en;
    logic [WORD_BITS-1:0] lo_word, hi_word, lo_raw, hi_raw;
    logic [EXT_W-2:0]     window;

    function automatic logic [1:0] word_src(input logic [K_W-1:0] kk,
                                            input logic [WIDX_W-1:0] c);
        if (KC_W'(kk) < KC_W'(c) && KC_W'(kk) < KC_W'(STORE_WORDS))
        begin
            return SRC_MEM;
        end
        else if (KC_W'(kk) == KC_W'(c))
        begin
            return SRC_PART;
        end
        return SRC_ZERO;
    endfunction

    always_comb
    begin
        free     = !res_valid_reg || !result_stall;
        start_op = (state_reg == S_IDLE) && head_valid && free;
        pop      = start_op;

        pos       = fill_reg[OFF_W-1:0];
        cur       = fill_reg[FILL_W-1:OFF_W];
        ext       = EXT_W'(head.entry) << pos;
        merged    = partial_reg | ext[WORD_BITS-1:0];
        fill_sum  = (FILL_W+1)'(fill_reg) + (FILL_W+1)'(head.width);
        pos_sum   = (OFF_W+1)'(pos) + (OFF_W+1)'(head.width);
        word_done = pos_sum[OFF_W];
        no_room   = (fill_sum > (FILL_W+1)'(STORE_BITS)) || (count_reg == COUNT_MAX);

        k         = head.start[START_W-1:OFF_W];
        k1        = k + 1'b1;
        odd_addr  = k[BANK_AW:1];
        even_addr = k[0] ? k1[BANK_AW:1] : k[BANK_AW:1];
        wr_addr   = cur[BANK_AW:1];

        state_next   = state_reg;
        fill_next    = fill_reg;
        count_next   = count_reg;
        partial_next = partial_reg;
        rd_ctl_next  = rd_ctl_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        load         = 1'b0;
        res_next     = res_reg;
        res_next.read_value = '0;
        res_next.status     = ST_OK;

        // spanning read: line up the two fetched words as lo/hi
        lo_raw  = rd_ctl_reg.k_odd ? rd_odd_reg : rd_even_reg;
        hi_raw  = rd_ctl_reg.k_odd ? rd_even_reg : rd_odd_reg;
        lo_word = (rd_ctl_reg.src_lo == SRC_MEM)  ? lo_raw :
                  (rd_ctl_reg.src_lo == SRC_PART) ? partial_reg : '0;
        hi_word = (rd_ctl_reg.src_hi == SRC_MEM)  ? hi_raw :
                  (rd_ctl_reg.src_hi == SRC_PART) ? partial_reg : '0;
        window  = {hi_word[MAX_ENTRY_BITS-2:0], lo_word} >> rd_ctl_reg.off;

        if (start_op)
        begin
            case (head.command)
                CMD_APPEND:
                begin
                    load = 1'b1;
                    if (head.val_bad)
                    begin
                        res_next.status = ST_VALUE;
                    end
                    else if (no_room)
                    begin
                        res_next.status = ST_FULL;
                    end
                    else
                    begin
                        fill_next  = fill_sum[FILL_W-1:0];
                        count_next = count_reg + 1'b1;
                        if (word_done)
                        begin
                            wr_en        = (KC_W'(cur) < KC_W'(STORE_WORDS));
                            partial_next = WORD_BITS'(ext[EXT_W-1:WORD_BITS]);
                        end
                        else
                        begin
                            partial_next = merged;
                        end
                    end
                end
                CMD_READ:
                begin
                    if (CNT_W'(head.index) >= count_reg)
                    begin
                        load            = 1'b1;
                        res_next.status = ST_INDEX;
                    end
                    else
                    begin
                        rd_en              = 1'b1;
                        state_next         = S_READ;
                        rd_ctl_next.k_odd  = k[0];
                        rd_ctl_next.off    = head.start[OFF_W-1:0];
                        rd_ctl_next.width  = head.width;
                        rd_ctl_next.src_lo = word_src(k, cur);
                        rd_ctl_next.src_hi = word_src(k1, cur);
                    end
                end
                CMD_CLEAR:
                begin
                    load         = 1'b1;
                    fill_next    = '0;
                    count_next   = '0;
                    partial_next = '0;
                end
                default:
                begin
                    load = 1'b1;
                end
            endcase
        end
        else if (state_reg == S_READ && free)
        begin
            load                = 1'b1;
            state_next          = S_IDLE;
            res_next.read_value = VAL_W'(window[MAX_ENTRY_BITS-1:0]
                                         & entry_mask(rd_ctl_reg.width));
        end

        res_next.entry_count = count_next;
        res_valid_next       = load || (res_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            count_reg     <= '0;
            partial_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            partial_reg   <= partial_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
        rd_ctl_reg <= rd_ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !cur[0])
        begin
            even_mem[wr_addr] <= merged;
        end
        if (rd_en)
        begin
            rd_even_reg <= even_mem[even_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && cur[0])
        begin
            odd_mem[wr_addr] <= merged;
        end
        if (rd_en)
        begin
            rd_odd_reg <= odd_mem[odd_addr];
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

### hdl/packed_palette_index_store.sv
// Top level of the packed palette index store: front decode, command queue, back end.
// Depends on ppis_pkg, ppis_front, ppis_queue, ppis_back.
//
// Usage:
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 palette_count,
//    index 1 air_index. cfg_ready is always high; write only while the block is idle.
//  - Item channel (item_valid/item_stall, item): a word is taken when valid is high and
//    stall is low. Commands: append, read entry at index, clear.
//  - Result channel (result_valid/result_stall, result): exactly one word per item, in
//    order. While result_stall is high the result word holds and the back end stops;
//    the two-deep command queue keeps taking items until it fills, then item_stall rises.
//  - Result path: append, clear and refused commands pass the command queue and the
//    result register; a read in range also passes the registered bank read.
//  - Throughput: one append per cycle while result_stall is low; a read holds the back
//    end in its read state for the registered word bank read. Words live in an even and
//    an odd bank so an entry that spans two words is fetched with one read of each.
//  - Appends collect in a 64-bit accumulator; a full word goes to its bank.
//  - Reset empties the store at once (entry count zero, config back to defaults);
//    the banks hold no reset state; a bank word not yet written may be fetched, but its data is never used.
module packed_palette_index_store
    import ppis_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result
);

    logic q_full;
    logic push;
    op_t  push_op;
    logic pop;
    logic head_valid;
    op_t  head;

    // decode side: config and per-item classification
    ppis_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_full     (q_full),
        .push       (push),
        .push_op    (push_op)
    );

    // decouples intake from the back end's stalls
    ppis_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // execution side: fill state, banks and result register
    ppis_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

### hdl/ppis_checker.sv
// Port-level checks for the packed palette index store, bound to the top level.
// Depends on ppis_pkg and packed_palette_index_store.
module ppis_checker
    import ppis_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data,
    input logic                  item_valid,
    input logic                  item_stall,
    input item_t                 item,
    input logic                  result_valid,
    input logic                  result_stall,
    input result_t               result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != ST_OK |-> result.read_value == '0)
        else $error("nonzero read value on refused command");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.entry_count <= ENTRY_LIMIT)
        else $error("entry count beyond store capacity");

endmodule

bind packed_palette_index_store ppis_checker u_ppis_checker (.*);

### tb/sv/palette_store_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the packed palette index store: keeps its own copy of the packed store,
// predicts every result word and compares it with the block. Depends on ppis_pkg.
module palette_store_checker
    import ppis_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  item_valid,
    input  logic                  item_stall,
    input  item_t                 item,
    input  logic                  result_valid,
    input  logic                  result_stall,
    input  result_t               result,
    output int                    mismatches,
    output int                    pending,
    output int                    results_checked,
    output int                    read_hits,
    output int                    full_refusals,
    output int                    value_refusals
);

    logic [WORD_BITS-1:0] store_copy [STORE_WORDS];
    logic [WORD_BITS-1:0] acc_word;
    int unsigned          entries;
    int unsigned          fill_bits;
    logic [PAL_W-1:0]     palette_count;
    logic [VAL_W-1:0]     air_index;
    result_t              expected_results [$];
    result_t              want;
    result_t              predicted;

    // bit length of palette_count-1, never below 2 nor above MAX_ENTRY_BITS
    function automatic int unsigned entry_width(input logic [PAL_W-1:0] pc);
        logic [PAL_W-1:0] top;
        int unsigned      n;
        top = (pc == '0) ? '0 : pc - 1'b1;
        n   = 2;
        for (int b = 2; b < PAL_W; b++)
        begin
            if (top[b])
            begin
                n = b + 1;
            end
        end
        return (n > MAX_ENTRY_BITS) ? MAX_ENTRY_BITS : n;
    endfunction

    // words past the fill word read as zero; the fill word is the accumulator
    function automatic logic [WORD_BITS-1:0] word_at(input int unsigned k);
        int unsigned fill_word;
        fill_word = fill_bits / WORD_BITS;
        if (k < fill_word && k < STORE_WORDS)
        begin
            return store_copy[k];
        end
        if (k == fill_word)
        begin
            return acc_word;
        end
        return '0;
    endfunction

    task automatic model_item(input item_t it, output result_t r);
        int unsigned          w;
        int unsigned          raw;
        int unsigned          swapped;
        int unsigned          pos;
        int unsigned          start;
        int unsigned          off;
        logic [WORD_BITS-1:0] bits;
        logic [WORD_BITS-1:0] mask;
        w    = entry_width(palette_count);
        mask = (64'd1 << w) - 64'd1;
        r    = '0;
        case (it.command)
            CMD_APPEND:
            begin
                raw     = it.value;
                swapped = raw;
                if (raw == 0)
                begin
                    swapped = air_index;
                end
                else if (raw == air_index)
                begin
                    swapped = 0;
                end
                if (raw >= palette_count || swapped >= palette_count)
                begin
                    r.status = ST_VALUE;
                    value_refusals++;
                end
                else if (fill_bits + w > STORE_BITS || entries >= COUNT_MAX)
                begin
                    r.status = ST_FULL;
                    full_refusals++;
                end
                else
                begin
                    pos      = fill_bits % WORD_BITS;
                    bits     = WORD_BITS'(swapped) & mask;
                    acc_word = acc_word | (bits << pos);
                    if (pos + w >= WORD_BITS)
                    begin
                        if (fill_bits / WORD_BITS < STORE_WORDS)
                        begin
                            store_copy[fill_bits / WORD_BITS] = acc_word;
                        end
                        // carry the spilled upper bits into the next word
                        acc_word = (pos + w > WORD_BITS) ? (bits >> (WORD_BITS - pos)) : '0;
                    end
                    fill_bits += w;
                    entries++;
                    r.status = ST_OK;
                end
            end
            CMD_READ:
            begin
                if (it.index >= entries)
                begin
                    r.status = ST_INDEX;
                end
                else
                begin
                    start = it.index * w;
                    off   = start % WORD_BITS;
                    bits  = word_at(start / WORD_BITS) >> off;
                    if (off + w > WORD_BITS)
                    begin
                        bits = bits | (word_at(start / WORD_BITS + 1) << (WORD_BITS - off));
                    end
                    r.read_value = VAL_W'(bits & mask);
                    r.status     = ST_OK;
                    read_hits++;
                end
            end
            CMD_CLEAR:
            begin
                entries   = 0;
                fill_bits = 0;
                acc_word  = '0;
            end
            default:
            begin
                // spare command: no effect
            end
        endcase
        r.entry_count = CNT_W'(entries);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_word        = '0;
            entries         = 0;
            fill_bits       = 0;
            palette_count   = PAL_W'(1);
            air_index       = '0;
            expected_results.delete();
            mismatches      = 0;
            pending         = 0;
            results_checked = 0;
            read_hits       = 0;
            full_refusals   = 0;
            value_refusals  = 0;
        end
        else
        begin
            // results first: a word accepted on this edge can never answer this edge's item
            if (result_valid && !result_stall)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("%0t: result word with nothing outstanding: value %0d status %0d count %0d",
                                 $time, result.read_value, result.status, result.entry_count);
                    end
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.read_value !== want.read_value || result.status !== want.status
                        || result.entry_count !== want.entry_count)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: mismatch exp/act value %0d/%0d status %0d/%0d count %0d/%0d",
                                     $time, want.read_value, result.read_value, want.status,
                                     result.status, want.entry_count, result.entry_count);
                        end
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_PALETTE_COUNT)
                begin
                    palette_count = cfg_data[PAL_W-1:0];
                end
                else if (cfg_index == REG_AIR_INDEX)
                begin
                    air_index = cfg_data[VAL_W-1:0];
                end
            end
            if (item_valid && !item_stall)
            begin
                model_item(item, predicted);
                expected_results.push_back(predicted);
            end
            pending = expected_results.size();
        end
    end

endmodule

### tb/sv/packed_palette_index_store_tb.sv
`timescale 1ns / 1ps
// Top of the packed palette index store testbench: clock, reset, stimulus and verdict.
// Depends on ppis_pkg, packed_palette_index_store and palette_store_checker.
module packed_palette_index_store_tb;
    import ppis_pkg::*;

    localparam int IDLE_PCT          = 11;    // per-cycle chance of a gap or a stall
    localparam int QUIET_LIMIT       = 2000;  // cycles without any handshake before giving up
    localparam int SETTLE_CYCLES     = 10;    // time for stray result words to show up after the drain
    localparam int RANDOM_SETTINGS   = 7;
    localparam int WORDS_PER_SETTING = 250;
    localparam int VAL_MAX           = (1 << VAL_W) - 1;
    localparam int IDX_MAX           = (1 << IDX_W) - 1;

    // the fourth command code has no meaning; the block must ignore it
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  item_valid;
    logic                  item_stall;
    item_t                 item;
    logic                  result_valid;
    logic                  result_stall;
    result_t               result;

    int mismatches;
    int pending;
    int results_checked;
    int read_hits;
    int full_refusals;
    int value_refusals;

    // stimulus-side bookkeeping, only used to shape the traffic
    logic             calm;       // no gaps and no stalls while set
    logic [PAL_W-1:0] cur_pc;
    logic [VAL_W-1:0] cur_air;
    int               est_count;  // appends since the last clear, an upper bound on entries
    int               settings;

    packed_palette_index_store u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    palette_store_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .item            (item),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .read_hits       (read_hits),
        .full_refusals   (full_refusals),
        .value_refusals  (value_refusals)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver side: random stalls, changed only on the falling edge.
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog: any accepted word on any channel (or reset) restarts the count.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending);
        $display("RESULT: ERROR");
        $finish;
    end

    // Offer one word, with an optional random gap first. Called and returns on a falling
    // edge; valid stays high on return so back-to-back words need no re-raise.
    task automatic send_word(input item_t w);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic issue(input logic [CMD_W-1:0] cmd, input int unsigned value,
                         input int unsigned index);
        item_t w;
        w.command = cmd;
        w.value   = VAL_W'(value);
        w.index   = IDX_W'(index);
        if (cmd == CMD_CLEAR)
        begin
            est_count = 0;
        end
        else if (cmd == CMD_APPEND && est_count < STORE_BITS / 2)
        begin
            est_count++;
        end
        send_word(w);
    endtask

    // Registers change only with the pipe drained: valid drops, every outstanding result
    // comes back, then both registers are written back to back.
    task automatic program_regs(input logic [PAL_W-1:0] pc, input logic [CFG_DATA_W-1:0] air);
        item_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= REG_PALETTE_COUNT;
        cfg_data  <= CFG_DATA_W'(pc);
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_index <= REG_AIR_INDEX;
        cfg_data  <= air;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_pc    = pc;
        cur_air   = air[VAL_W-1:0];
        settings++;
    endtask

    // Mostly appends of legal values and reads inside the filled range, with some
    // out-of-range values and indices, the odd clear and the spare command.
    task automatic random_item();
        int unsigned pick;
        int unsigned value;
        int unsigned index;
        int unsigned top_value;
        pick      = $urandom_range(99);
        top_value = (cur_pc == '0) ? 0 : ((cur_pc > VAL_MAX) ? VAL_MAX : cur_pc - 1);
        if (pick < 58)
        begin
            case ($urandom_range(9))
                0:       value = 0;
                1:       value = cur_air;
                2:       value = $urandom_range(VAL_MAX);
                default: value = $urandom_range(top_value);
            endcase
            issue(CMD_APPEND, value, $urandom_range(IDX_MAX));
        end
        else if (pick < 94)
        begin
            case ($urandom_range(9))
                7, 8:    index = $urandom_range(IDX_MAX);
                9:       index = IDX_MAX;
                default: index = $urandom_range(est_count + 1);
            endcase
            issue(CMD_READ, $urandom_range(VAL_MAX), index);
        end
        else if (pick < 97)
        begin
            issue(CMD_CLEAR, $urandom_range(VAL_MAX), $urandom_range(IDX_MAX));
        end
        else
        begin
            issue(CMD_SPARE, $urandom_range(VAL_MAX), $urandom_range(IDX_MAX));
        end
    endtask

    initial
    begin
        int               n;
        int               s;
        logic [PAL_W-1:0] pc;

        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        item_valid = 1'b0;
        item       = '0;
        calm       = 1'b0;
        cur_pc     = PAL_W'(1);
        cur_air    = '0;
        est_count  = 0;
        settings   = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- directed: 7-bit entries, so entry 9 straddles words 0 and 1 ---
        program_regs(13'd100, 13'd99);
        issue(CMD_READ, 0, 0);                  // empty store
        issue(CMD_APPEND, 0, 0);                // zero swaps to air
        issue(CMD_APPEND, 99, 0);               // air swaps to zero
        issue(CMD_APPEND, 100, 0);              // raw value too large
        issue(CMD_APPEND, VAL_MAX, IDX_MAX);
        issue(CMD_SPARE, VAL_MAX, IDX_MAX);
        for (n = 0; n < 8; n++)
        begin
            issue(CMD_APPEND, $urandom_range(1, 98), 0);
        end
        issue(CMD_READ, 0, 9);                  // spanning entry
        issue(CMD_READ, 0, 0);
        issue(CMD_READ, 0, 1);
        issue(CMD_READ, 0, 10);                 // first index past the fill
        issue(CMD_READ, VAL_MAX, IDX_MAX);
        issue(CMD_CLEAR, 0, 0);
        issue(CMD_READ, 0, 0);
        issue(CMD_APPEND, 1, 0);

        // palette_count zero behaves like one: 2-bit width, every append refused;
        // the read reinterprets the 7-bit entry at 2 bits
        program_regs(13'd0, 13'd4095);
        issue(CMD_APPEND, 0, 0);
        issue(CMD_APPEND, VAL_MAX, 0);
        issue(CMD_READ, 0, 0);

        // air outside the palette: the swapped value is what gets refused
        program_regs(13'd8, 13'd12);
        issue(CMD_APPEND, 0, 0);
        issue(CMD_APPEND, 12, 0);
        issue(CMD_APPEND, 3, 0);
        issue(CMD_READ, 0, 1);
        issue(CMD_READ, 0, 0);

        // --- random traffic over a spread of register settings, store not cleared
        //     between settings so old entries are read at new widths ---
        for (s = 0; s < RANDOM_SETTINGS; s++)
        begin
            case (s)
                0:       program_regs(13'd3, 13'd2);
                1:       program_regs(13'd1, 13'd0);
                2:       program_regs(13'd4096, 13'd4095);
                3:       program_regs(13'd8191, 13'h1ABC);   // upper data bit dropped for air
                4:       program_regs(13'd37, 13'd40);
                5:       program_regs(13'd5, 13'd4);
                default:
                begin
                    pc = PAL_W'($urandom_range(2, 4096));
                    program_regs(pc, CFG_DATA_W'($urandom_range(pc - 1)));
                end
            endcase
            calm = (s == 2);
            if (s == 0)
            begin
                issue(CMD_CLEAR, 0, 0);
            end
            for (n = 0; n < WORDS_PER_SETTING; n++)
            begin
                random_item();
            end
        end
        calm = 1'b0;

        // drain, then give stray words time to show up
        item_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Covered %0d register settings and %0d result words: %0d in-range reads,",
                 settings, results_checked, read_hits);
        $display("%0d full-store and %0d bad-value refusals; %0d mismatches, %0d still owed.",
                 full_refusals, value_refusals, mismatches, pending);
        if (mismatches == 0 && pending == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### sim.f
hdl/ppis_pkg.sv
hdl/ppis_front.sv
hdl/ppis_queue.sv
hdl/ppis_back.sv
hdl/packed_palette_index_store.sv
hdl/ppis_checker.sv
tb/sv/palette_store_checker.sv
tb/sv/packed_palette_index_store_tb.sv
